>>> hdl/joypad_decode_autorepeat_core_assert.svh
// ---------------------------------------------------------------------------
// joypad decode autorepeat assertion macros
// shared property forms for the core checks
// ---------------------------------------------------------------------------
`ifndef JOYPAD_DECODE_AUTOREPEAT_CORE_ASSERT_SVH
`define JOYPAD_DECODE_AUTOREPEAT_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jda check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define JDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jda check failed: next-cycle implication");

`endif

>>> hdl/jda_pkg.sv
// ---------------------------------------------------------------------------
// jda_pkg
// types, codes and constants of the joypad decoder with autorepeat
// ---------------------------------------------------------------------------
`default_nettype none

package jda_pkg;

    localparam int KEY_W   = 3;
    localparam int KIND_W  = 2;
    localparam int PAD_W   = 5;
    localparam int CNT_W   = 16;

    localparam logic [KEY_W-1:0] KC_NONE  = 3'd0;
    localparam logic [KEY_W-1:0] KC_LEFT  = 3'd1;
    localparam logic [KEY_W-1:0] KC_RIGHT = 3'd2;
    localparam logic [KEY_W-1:0] KC_UP    = 3'd3;
    localparam logic [KEY_W-1:0] KC_DOWN  = 3'd4;
    localparam logic [KEY_W-1:0] KC_ENTER = 3'd5;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic REG_DELAY  = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [3:0] DIAG_NONE  = 4'h0;
    localparam logic [3:0] DIAG_LEFT  = 4'h5;
    localparam logic [3:0] DIAG_RIGHT = 4'hA;
    localparam logic [3:0] DIAG_UP    = 4'h9;
    localparam logic [3:0] DIAG_DOWN  = 4'h6;

    localparam logic [CNT_W-1:0] RESET_DELAY  = 16'd250;
    localparam logic [CNT_W-1:0] RESET_PERIOD = 16'd100;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic              last;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } event_t;

    function automatic logic [CNT_W-1:0] load_value(input logic [CNT_W-1:0] ticks);
        return (ticks == '0) ? CNT_W'(1) : ticks;
    endfunction

    function automatic logic [KEY_W-1:0] decode_pad(input logic [PAD_W-1:0] pad);
        logic [PAD_W-1:0] pressed;
        logic [KEY_W-1:0] key;
        pressed = ~pad;
        unique case (pressed[3:0])
            DIAG_LEFT:  key = KC_LEFT;
            DIAG_RIGHT: key = KC_RIGHT;
            DIAG_UP:    key = KC_UP;
            DIAG_DOWN:  key = KC_DOWN;
            DIAG_NONE:  key = pressed[4] ? KC_ENTER : KC_NONE;
            default:    key = KC_NONE;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

>>> hdl/joypad_decode_autorepeat_core.sv
// ---------------------------------------------------------------------------
// joypad_decode_autorepeat_core
// joypad contact decoder with key press, release and autorepeat events
// ---------------------------------------------------------------------------
// usage:
//   s_* carries input beats: s_tuser is the kind (0 pad sample, 1 ms tick),
//   s_tdata[4:0] the active-low contacts. m_* carries key events, with
//   m_tlast on the final event caused by one input beat.
//   cfg_* writes repeat_delay (index 0) or repeat_period (index 1);
//   cfg_ready is always high, write only while the block is idle.
// latency and throughput:
//   an input beat updates the key state in the cycle it is accepted and
//   its events are in the output queue the next cycle, which drives
//   m_tvalid high. one input beat per cycle is accepted while the
//   four-entry output queue has room for two events; a beat that
//   yields two events needs two output transfers, so that mix is bounded
//   by the one-event-per-cycle output port.
// reset:
//   rst_n clears held key, repeat state and the queue, and loads delay 250
//   and period 100. a stalled receiver lets the queue fill until fewer than
//   two entries are free, and then s_tready drops until entries drain.
// ---------------------------------------------------------------------------
`default_nettype none

module joypad_decode_autorepeat_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [4:0] pad_bits, [7:5] zero
    input  wire logic        s_tuser,     // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // [2:0] event_key, [4:3] event_kind, [7:5] zero
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [jda_pkg::CNT_W-1:0] repeat_delay_reg;
    logic [jda_pkg::CNT_W-1:0] repeat_period_reg;
    logic [jda_pkg::KEY_W-1:0] held_key_reg, held_key_next;
    logic                      repeat_armed_reg, repeat_armed_next;
    logic [jda_pkg::CNT_W-1:0] repeat_count_reg, repeat_count_next;

    jda_pkg::event_t           fifo_reg [jda_pkg::FIFO_DEPTH];
    logic [jda_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [jda_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [jda_pkg::FCNT_W-1:0] fifo_count_reg, fifo_count_next;

    logic                      in_fire;
    logic                      out_fire;
    logic [jda_pkg::KEY_W-1:0] dec_key;
    logic [jda_pkg::CNT_W-1:0] cnt_dec;
    jda_pkg::event_t           ev_a;
    jda_pkg::event_t           ev_b;
    logic [1:0]                ev_n;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign s_tready  = fifo_count_reg <= jda_pkg::FCNT_W'(jda_pkg::FIFO_DEPTH - 2);
    assign cfg_ready = 1'b1;
    assign dec_key   = jda_pkg::decode_pad(s_tdata[jda_pkg::PAD_W-1:0]);
    assign cnt_dec   = repeat_count_reg - jda_pkg::CNT_W'(1);

    // event generation and key state update
    always_comb
    begin
        held_key_next     = held_key_reg;
        repeat_armed_next = repeat_armed_reg;
        repeat_count_next = repeat_count_reg;
        ev_a              = '{last: 1'b1, kind: jda_pkg::KIND_RELEASE, key: held_key_reg};
        ev_b              = '{last: 1'b1, kind: jda_pkg::KIND_PRESS, key: dec_key};
        ev_n              = 2'd0;
        if (in_fire)
        begin
            if (s_tuser == jda_pkg::FUNC_TICK)
            begin
                if (repeat_armed_reg)
                begin
                    if (cnt_dec == '0)
                    begin
                        ev_a.kind         = jda_pkg::KIND_REPEAT;
                        ev_n              = 2'd1;
                        repeat_count_next = jda_pkg::load_value(repeat_period_reg);
                    end
                    else
                    begin
                        repeat_count_next = cnt_dec;
                    end
                end
            end
            else if (dec_key != held_key_reg)
            begin
                repeat_armed_next = 1'b0;
                held_key_next     = dec_key;
                if (held_key_reg != jda_pkg::KC_NONE)
                begin
                    ev_n      = 2'd1;
                    ev_a.last = (dec_key == jda_pkg::KC_NONE);
                end
                if (dec_key != jda_pkg::KC_NONE)
                begin
                    if (held_key_reg != jda_pkg::KC_NONE)
                    begin
                        ev_n = 2'd2;
                    end
                    else
                    begin
                        ev_a = ev_b;
                        ev_n = 2'd1;
                    end
                    if (dec_key != jda_pkg::KC_ENTER)
                    begin
                        repeat_armed_next = 1'b1;
                        repeat_count_next = jda_pkg::load_value(repeat_delay_reg);
                    end
                end
            end
        end
    end

    // output queue pointers
    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg + jda_pkg::PTR_W'(ev_n);
        rd_ptr_next     = rd_ptr_reg + jda_pkg::PTR_W'(out_fire);
        fifo_count_next = fifo_count_reg + jda_pkg::FCNT_W'(ev_n)
                          - jda_pkg::FCNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg  <= jda_pkg::RESET_DELAY;
            repeat_period_reg <= jda_pkg::RESET_PERIOD;
            held_key_reg      <= jda_pkg::KC_NONE;
            repeat_armed_reg  <= 1'b0;
            repeat_count_reg  <= '0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            fifo_count_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == jda_pkg::REG_DELAY)
                begin
                    repeat_delay_reg <= cfg_data;
                end
                else
                begin
                    repeat_period_reg <= cfg_data;
                end
            end
            held_key_reg     <= held_key_next;
            repeat_armed_reg <= repeat_armed_next;
            repeat_count_reg <= repeat_count_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            fifo_count_reg   <= fifo_count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (ev_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= ev_a;
        end
        if (ev_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + jda_pkg::PTR_W'(1)] <= ev_b;
        end
    end

    assign m_tvalid = fifo_count_reg != '0;
    assign m_tdata  = {3'b000, fifo_reg[rd_ptr_reg].kind, fifo_reg[rd_ptr_reg].key};
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

`include "joypad_decode_autorepeat_core_assert.svh"

    `JDA_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_count_reg <= jda_pkg::FCNT_W'(jda_pkg::FIFO_DEPTH))
    `JDA_ASSERT_SAME(a_armed_key, repeat_armed_reg, (held_key_reg != jda_pkg::KC_NONE) && (held_key_reg != jda_pkg::KC_ENTER))
    `JDA_ASSERT_SAME(a_armed_count, repeat_armed_reg, repeat_count_reg != '0)
    `JDA_ASSERT_NEXT(a_pair_queued, ev_n == 2'd2, fifo_count_reg >= jda_pkg::FCNT_W'(2))

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joypad decode autorepeat testbench
// drives pad samples and ms ticks into the core, predicts the key events
// with an in-bench copy of the key and repeat state, checks every event
// ----------------------------------------------------------------------------

module testbench;

    import jda_pkg::*;

    typedef struct {
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic              last;
    } key_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [4:0] pad_bits, [7:5] zero
    logic        s_tuser;    // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [2:0] event_key, [4:3] event_kind, [7:5] zero
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    key_event_t       expected_events[$];
    logic [KEY_W-1:0] key_held_q;
    logic             armed_q;
    logic [CNT_W-1:0] count_q;
    logic [CNT_W-1:0] delay_q;
    logic [CNT_W-1:0] period_q;

    int   errors_seen;
    int   items_sent;
    int   hold_off;
    logic idle_on;
    key_event_t front_ev;

    joypad_decode_autorepeat_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors_seen < 40)
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        errors_seen++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [KEY_W-1:0] key_of_pad(input logic [PAD_W-1:0] pad);
        logic [PAD_W-1:0] down;
        down = ~pad;
        case (down[3:0])
            DIAG_LEFT:  return KC_LEFT;
            DIAG_RIGHT: return KC_RIGHT;
            DIAG_UP:    return KC_UP;
            DIAG_DOWN:  return KC_DOWN;
            DIAG_NONE:  return down[4] ? KC_ENTER : KC_NONE;
            default:    return KC_NONE;
        endcase
    endfunction

    function automatic logic [PAD_W-1:0] pad_for_key(input logic [KEY_W-1:0] key);
        logic [3:0]       diag;
        logic             act;
        logic [PAD_W-1:0] pad;
        act  = 1'($urandom_range(0, 1));
        diag = DIAG_NONE;
        case (key)
            KC_LEFT:  diag = DIAG_LEFT;
            KC_RIGHT: diag = DIAG_RIGHT;
            KC_UP:    diag = DIAG_UP;
            KC_DOWN:  diag = DIAG_DOWN;
            KC_ENTER: act = 1'b1;
            default:   ;
        endcase
        pad = ~{act, diag};
        if (key == KC_NONE)
            do
                pad = PAD_W'($urandom_range(0, 31));
            while (key_of_pad(pad) != KC_NONE);
        return pad;
    endfunction

    function automatic logic [CNT_W-1:0] reload(input logic [CNT_W-1:0] ticks);
        return (ticks == '0) ? CNT_W'(1) : ticks;
    endfunction

    task automatic push_event(input logic [KEY_W-1:0] key, input logic [KIND_W-1:0] kind);
        key_event_t ev;
        ev.key  = key;
        ev.kind = kind;
        ev.last = 1'b0;
        expected_events.push_back(ev);
    endtask

    task automatic predict_events(input logic func, input logic [PAD_W-1:0] pad);
        logic [KEY_W-1:0] key;
        int               first_idx;
        key_event_t       tail;
        first_idx = expected_events.size();
        if (func == FUNC_TICK)
        begin
            if (armed_q)
            begin
                count_q = count_q - CNT_W'(1);
                if (count_q == '0)
                begin
                    push_event(key_held_q, KIND_REPEAT);
                    count_q = reload(period_q);
                end
            end
        end
        else
        begin
            key = key_of_pad(pad);
            if (key != key_held_q)
            begin
                if (key_held_q != KC_NONE)
                    push_event(key_held_q, KIND_RELEASE);
                armed_q = 1'b0;
                if (key != KC_NONE)
                begin
                    push_event(key, KIND_PRESS);
                    if (key != KC_ENTER)
                    begin
                        armed_q = 1'b1;
                        count_q = reload(delay_q);
                    end
                end
                key_held_q = key;
            end
        end
        if (expected_events.size() > first_idx)
        begin
            tail = expected_events.pop_back();
            tail.last = 1'b1;
            expected_events.push_back(tail);
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic func, input logic [PAD_W-1:0] pad);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {3'b000, pad};
        do
            @(posedge clk);
        while (!s_tready);
        predict_events(func, pad);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_DELAY)
            delay_q = value;
        else
            period_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] dly, input logic [15:0] per);
        write_reg(REG_DELAY, dly);
        write_reg(REG_PERIOD, per);
    endtask

    task automatic test_default_timing();
        send_item(FUNC_SAMPLE, pad_for_key(KC_LEFT));
        repeat (355) send_item(FUNC_TICK, PAD_W'($urandom_range(0, 31)));
        send_item(FUNC_SAMPLE, 5'h1F);
        wait_drain();
    endtask

    task automatic test_decode_patterns();
        send_item(FUNC_SAMPLE, 5'h1F);
        send_item(FUNC_SAMPLE, 5'h00);
        send_item(FUNC_SAMPLE, 5'(~{1'b1, DIAG_NONE}));
        send_item(FUNC_SAMPLE, 5'(~{1'b1, DIAG_LEFT}));
        send_item(FUNC_SAMPLE, 5'(~{1'b0, DIAG_RIGHT}));
        send_item(FUNC_SAMPLE, 5'(~{1'b0, DIAG_UP}));
        send_item(FUNC_SAMPLE, 5'(~{1'b1, DIAG_DOWN}));
        // nw + se with action: not a pair
        send_item(FUNC_SAMPLE, 5'(~{1'b1, 4'h3}));
        // single nw: still no key
        send_item(FUNC_SAMPLE, 5'(~{1'b0, 4'h1}));
        send_item(FUNC_SAMPLE, 5'(~{1'b1, DIAG_NONE}));
        send_item(FUNC_SAMPLE, 5'h1F);
    endtask

    task automatic test_enter_no_repeat();
        set_timing(16'd1, 16'd1);
        send_item(FUNC_SAMPLE, pad_for_key(KC_ENTER));
        repeat (3) send_item(FUNC_TICK, 5'h00);
        send_item(FUNC_SAMPLE, 5'h1F);
        send_item(FUNC_TICK, 5'h1F);
    endtask

    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0);
        send_item(FUNC_SAMPLE, 5'(~{1'b0, DIAG_DOWN}));
        repeat (3) send_item(FUNC_TICK, 5'h1F);
        send_item(FUNC_SAMPLE, 5'(~{1'b1, DIAG_DOWN}));
        send_item(FUNC_TICK, 5'h00);
        send_item(FUNC_SAMPLE, 5'h1F);
    endtask

    task automatic test_write_while_armed();
        set_timing(16'd4, 16'd3);
        send_item(FUNC_SAMPLE, pad_for_key(KC_UP));
        repeat (2) send_item(FUNC_TICK, 5'h15);
        write_reg(REG_PERIOD, 16'd1);
        write_reg(REG_DELAY, 16'd65535);
        repeat (4) send_item(FUNC_TICK, 5'h0A);
        send_item(FUNC_SAMPLE, pad_for_key(KC_RIGHT));
        send_item(FUNC_SAMPLE, 5'h1F);
    endtask

    task automatic test_backpressure();
        set_timing(16'd2, 16'd1);
        idle_on  = 1'b0;
        hold_off = 150;
        for (int i = 0; i < 16; i++)
            send_item(FUNC_SAMPLE, pad_for_key(i[0] ? KC_LEFT : KC_RIGHT));
        repeat (8) send_item(FUNC_TICK, 5'h00);
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic run_random_phase(input logic [15:0] dly, input logic [15:0] per,
                                    input int n_items);
        int span;
        int stop_at;
        int r;
        set_timing(dly, per);
        span = int'(dly) + 3 * int'(per);
        if (span > 40)
            span = 40;
        if (span < 3)
            span = 3;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                send_item(FUNC_SAMPLE, pad_for_key(KEY_W'($urandom_range(1, 5))));
                repeat ($urandom_range(0, span))
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_item(FUNC_SAMPLE, pad_for_key(key_held_q));
                    else
                        send_item(FUNC_TICK, PAD_W'($urandom_range(0, 31)));
                end
                if ($urandom_range(0, 9) < 7)
                    send_item(FUNC_SAMPLE, pad_for_key(KC_NONE));
            end
            else if (r < 9)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), PAD_W'($urandom_range(0, 31)));
            end
            else
            begin
                // press cut short by an immediate release
                send_item(FUNC_SAMPLE, pad_for_key(KEY_W'($urandom_range(1, 4))));
                send_item(FUNC_SAMPLE, pad_for_key(KC_NONE));
                send_item(FUNC_TICK, PAD_W'($urandom_range(0, 31)));
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        run_random_phase(16'd1, 16'd1, 52);
        run_random_phase(16'd0, 16'd0, 52);
        run_random_phase(16'd2, 16'd3, 52);
        run_random_phase(16'd65535, 16'd65535, 52);
        run_random_phase(16'd0, 16'd5, 52);
        run_random_phase(16'd7, 16'd0, 52);
        run_random_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), 52);
        run_random_phase(16'd3, 16'd1, 52);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
                report_mismatch("event with nothing expected", m_tdata, 0);
            else
            begin
                front_ev = expected_events.pop_front();
                if (m_tdata[2:0] != front_ev.key)
                    report_mismatch("event_key", m_tdata[2:0], front_ev.key);
                if (m_tdata[4:3] != front_ev.kind)
                    report_mismatch("event_kind", m_tdata[4:3], front_ev.kind);
                if (m_tlast !== front_ev.last)
                    report_mismatch("last_of_run", m_tlast, front_ev.last);
                if (m_tdata[7:5] != 3'b000)
                    report_mismatch("tdata padding", m_tdata[7:5], 0);
            end
        end
    end

    initial
    begin : event_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int spin;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_DELAY;
        cfg_data   = '0;
        key_held_q = KC_NONE;
        armed_q    = 1'b0;
        count_q    = '0;
        delay_q    = RESET_DELAY;
        period_q   = RESET_PERIOD;
        errors_seen = 0;
        items_sent = 0;
        hold_off   = 0;
        idle_on    = 1'b1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_timing();
        test_decode_patterns();
        test_enter_no_repeat();
        test_zero_timing();
        test_write_while_armed();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        for (spin = 0; spin < 5000 && expected_events.size() != 0; spin++)
            @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch("events never delivered", expected_events.size(), 0);
        repeat (20) @(posedge clk);
        if (errors_seen == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/jda_pkg.sv
hdl/joypad_decode_autorepeat_core.sv
test/testbench.sv
